// ===== rtl/h2r_pkg.sv =====
// h2r_pkg: shared types and constants for the HSV to RGB converter.
// No dependencies; imported by every module under rtl/.
package h2r_pkg;

    localparam int LATENCY = 8;

    // hue arithmetic, hue in 1/64 degree units
    localparam logic [24:0] HUE_OFFSET = 25'd8409600;   // 365 turns, makes any hue positive
    localparam logic [14:0] HUE_TURN   = 15'd23040;
    localparam logic [11:0] HUE_SECTOR = 12'd3840;
    localparam logic [10:0] RECIP_45   = 11'd1456;      // floor(2^16 / 45)
    localparam logic [5:0]  TURN_DIV   = 6'd45;         // 23040 = 45 * 2^9
    localparam logic [12:0] RECIP_15   = 13'd4369;      // floor(2^16 / 15)
    localparam logic [3:0]  FRAC_DIV   = 4'd15;         // 3840 = 15 * 2^8

    localparam logic signed [29:0] ONE_Q24 = 30'sd16777216;
    localparam logic signed [46:0] HALF_Q24 = 47'sd8388608;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    // sideband that travels alongside the hue math
    typedef struct packed {
        logic               vld;
        logic signed [15:0] sat;
        logic signed [15:0] bri;
        logic signed [15:0] alp;
    } t_pix;

endpackage

// ===== rtl/hsv_to_rgb_converter.sv =====
// hsv_to_rgb_converter: top level of the pipelined HSV to RGB converter.
// Depends on h2r_pkg, h2r_hue_wrap, h2r_sector and h2r_terms.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | start, busy        | i_hue, i_saturation, i_brightness, i_alpha
//  result   | o_valid (strobe)   | o_red, o_green, o_blue, o_alpha_out
//
// One item per clock; each result passes through the eight register stages
// (hue wrap 3, sector split 2, multiply/round/route 3).
// busy is always low: the pipeline never stalls and the receiver cannot hold
// results off. Synchronous active-low reset clears only the valid bits.
module hsv_to_rgb_converter import h2r_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] i_hue,
    input  logic signed [15:0] i_saturation,
    input  logic signed [15:0] i_brightness,
    input  logic signed [15:0] i_alpha,
    output logic               o_valid,
    output logic signed [15:0] o_red,
    output logic signed [15:0] o_green,
    output logic signed [15:0] o_blue,
    output logic signed [15:0] o_alpha_out
);

    t_pix        w_pix_in, w_pix_wr, w_pix_sec;
    logic [14:0] w_h;
    t_sector     w_sec;
    logic [11:0] w_f;

    assign busy = 1'b0;

    assign w_pix_in.vld = start & ~busy;
    assign w_pix_in.sat = i_saturation;
    assign w_pix_in.bri = i_brightness;
    assign w_pix_in.alp = i_alpha;

    h2r_hue_wrap u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (w_pix_in),
        .i_hue   (i_hue),
        .o_pix   (w_pix_wr),
        .o_h     (w_h)
    );

    h2r_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (w_pix_wr),
        .i_h     (w_h),
        .o_pix   (w_pix_sec),
        .o_sec   (w_sec),
        .o_f     (w_f)
    );

    h2r_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (w_pix_sec),
        .i_sec   (w_sec),
        .i_f     (w_f),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue),
        .o_alpha (o_alpha_out)
    );

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without a matching item");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_alpha_out == $past(i_alpha, LATENCY))
        else $error("alpha not carried with its item");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_saturation, LATENCY) == 16'sd0) |->
        (o_red == $past(i_brightness, LATENCY) && o_green == o_red && o_blue == o_red))
        else $error("zero saturation did not give grey");
`endif

endmodule

// ===== rtl/h2r_hue_wrap.sv =====
// h2r_hue_wrap: three-stage reduction of signed hue modulo one turn.
// Depends on h2r_pkg.
module h2r_hue_wrap import h2r_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pix               i_pix,
    input  logic signed [23:0] i_hue,
    output t_pix               o_pix,
    output logic [14:0]        o_h
);

    t_pix        r_pix1, r_pix2, r_pix3;
    logic [24:0] r_x1, r_x2;
    logic [9:0]  r_q2;
    logic [14:0] r_h3;

    logic [24:0] n_x1;
    logic [26:0] w_qprod;
    logic [9:0]  n_q2;
    logic [15:0] w_q45;
    logic [15:0] w_rem;
    logic [14:0] n_h3;

    // offset hue is positive and below 2^25
    assign n_x1 = {i_hue[23], i_hue} + HUE_OFFSET;

    // quotient estimate by reciprocal: equal to the true quotient or one less
    assign w_qprod = r_x1[24:9] * RECIP_45;
    assign n_q2    = w_qprod[25:16];

    assign w_q45 = 16'(r_q2 * TURN_DIV);
    assign w_rem = 16'(r_x2 - {w_q45, 9'd0});

    always_comb begin
        if (w_rem >= {1'b0, HUE_TURN}) begin
            n_h3 = 15'(w_rem - {1'b0, HUE_TURN});
        end else begin
            n_h3 = w_rem[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix1.vld <= 1'b0;
            r_pix2.vld <= 1'b0;
            r_pix3.vld <= 1'b0;
        end else begin
            r_pix1.vld <= i_pix.vld;
            r_pix2.vld <= r_pix1.vld;
            r_pix3.vld <= r_pix2.vld;
        end
        r_pix1.sat <= i_pix.sat;
        r_pix1.bri <= i_pix.bri;
        r_pix1.alp <= i_pix.alp;
        r_pix2.sat <= r_pix1.sat;
        r_pix2.bri <= r_pix1.bri;
        r_pix2.alp <= r_pix1.alp;
        r_pix3.sat <= r_pix2.sat;
        r_pix3.bri <= r_pix2.bri;
        r_pix3.alp <= r_pix2.alp;
        r_x1       <= n_x1;
        r_x2       <= r_x1;
        r_q2       <= n_q2;
        r_h3       <= n_h3;
    end

    assign o_pix = r_pix3;
    assign o_h   = r_h3;

endmodule

// ===== rtl/h2r_sector.sv =====
// h2r_sector: splits wrapped hue into sector and Q0.12 fraction, two stages.
// Depends on h2r_pkg.
module h2r_sector import h2r_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pix        i_pix,
    input  logic [14:0] i_h,
    output t_pix        o_pix,
    output t_sector     o_sec,
    output logic [11:0] o_f
);

    t_pix        r_pix4, r_pix5;
    t_sector     r_sec4, r_sec5;
    logic [11:0] r_r4;
    logic [11:0] r_f5;

    t_sector     n_sec4;
    logic [14:0] w_base;
    logic [11:0] n_r4;
    logic [15:0] w_z;
    logic [28:0] w_fprod;
    logic [11:0] w_fe;
    logic [15:0] w_fe15;
    logic [11:0] n_f5;

    always_comb begin
        if (i_h >= 15'd19200) begin
            n_sec4 = SEC_MAG_RED;
            w_base = 15'd19200;
        end else if (i_h >= 15'd15360) begin
            n_sec4 = SEC_BLU_MAG;
            w_base = 15'd15360;
        end else if (i_h >= 15'd11520) begin
            n_sec4 = SEC_CYN_BLU;
            w_base = 15'd11520;
        end else if (i_h >= 15'd7680) begin
            n_sec4 = SEC_GRN_CYN;
            w_base = 15'd7680;
        end else if (i_h >= {3'd0, HUE_SECTOR}) begin
            n_sec4 = SEC_YEL_GRN;
            w_base = {3'd0, HUE_SECTOR};
        end else begin
            n_sec4 = SEC_RED_YEL;
            w_base = 15'd0;
        end
    end

    assign n_r4 = 12'(i_h - w_base);

    // f = floor(r * 16 / 15); estimate is exact or one low
    assign w_z     = {r_r4, 4'd0};
    assign w_fprod = w_z * RECIP_15;
    assign w_fe    = w_fprod[27:16];
    assign w_fe15  = 16'(w_z - 16'(w_fe * FRAC_DIV));

    always_comb begin
        if (w_fe15 >= {12'd0, FRAC_DIV}) begin
            n_f5 = w_fe + 12'd1;
        end else begin
            n_f5 = w_fe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix4.vld <= 1'b0;
            r_pix5.vld <= 1'b0;
        end else begin
            r_pix4.vld <= i_pix.vld;
            r_pix5.vld <= r_pix4.vld;
        end
        r_pix4.sat <= i_pix.sat;
        r_pix4.bri <= i_pix.bri;
        r_pix4.alp <= i_pix.alp;
        r_pix5.sat <= r_pix4.sat;
        r_pix5.bri <= r_pix4.bri;
        r_pix5.alp <= r_pix4.alp;
        r_sec4     <= n_sec4;
        r_sec5     <= r_sec4;
        r_r4       <= n_r4;
        r_f5       <= n_f5;
    end

    assign o_pix = r_pix5;
    assign o_sec = r_sec5;
    assign o_f   = r_f5;

`ifndef NO_ASSERTIONS
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix4.vld |-> (r_sec4 <= SEC_MAG_RED && r_r4 < HUE_SECTOR))
        else $error("sector split out of range");

    a_sector_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix5.vld |-> r_sec5 == $past(r_sec4))
        else $error("sector lost alignment with fraction");
`endif

endmodule

// ===== rtl/h2r_terms.sv =====
// h2r_terms: p/q/t terms, rounding, saturation and six-sector routing.
// Three stages; depends on h2r_pkg.
module h2r_terms import h2r_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pix               i_pix,
    input  t_sector            i_sec,
    input  logic [11:0]        i_f,
    output logic               o_valid,
    output logic signed [15:0] o_red,
    output logic signed [15:0] o_green,
    output logic signed [15:0] o_blue,
    output logic signed [15:0] o_alpha
);

    t_pix               r_pix6, r_pix7;
    t_sector            r_sec6, r_sec7;
    logic signed [29:0] r_in_p, r_in_q, r_in_t;
    logic signed [45:0] r_pr_p, r_pr_q, r_pr_t;
    logic               r_valid;
    logic signed [15:0] r_red, r_green, r_blue, r_alpha;

    logic signed [28:0] w_sf;
    logic signed [29:0] w_s12;
    logic signed [29:0] n_in_p, n_in_q, n_in_t;
    logic signed [45:0] n_pr_p, n_pr_q, n_pr_t;
    logic signed [46:0] w_sum_p, w_sum_q, w_sum_t;
    logic signed [15:0] w_p, w_q, w_t, w_v;
    logic signed [15:0] n_red, n_green, n_blue;

    function automatic logic signed [15:0] sat16(input logic signed [22:0] x);
        if (x > 23'sd32767) begin
            sat16 = 16'sh7FFF;
        end else if (x < -23'sd32768) begin
            sat16 = -16'sh8000;
        end else begin
            sat16 = x[15:0];
        end
    endfunction

    // stage 6: 1 - S*g in Q24 for g = 1, f, 1 - f
    assign w_sf   = i_pix.sat * $signed({1'b0, i_f});
    assign w_s12  = {{2{i_pix.sat[15]}}, i_pix.sat, 12'd0};
    assign n_in_p = ONE_Q24 - w_s12;
    assign n_in_q = ONE_Q24 - 30'(w_sf);
    assign n_in_t = ONE_Q24 - w_s12 + 30'(w_sf);

    // stage 7: V * inner
    assign n_pr_p = r_pix6.bri * r_in_p;
    assign n_pr_q = r_pix6.bri * r_in_q;
    assign n_pr_t = r_pix6.bri * r_in_t;

    // stage 8: round half up, floor shift, clamp, route
    assign w_sum_p = 47'(r_pr_p) + HALF_Q24;
    assign w_sum_q = 47'(r_pr_q) + HALF_Q24;
    assign w_sum_t = 47'(r_pr_t) + HALF_Q24;
    assign w_p     = sat16(w_sum_p[46:24]);
    assign w_q     = sat16(w_sum_q[46:24]);
    assign w_t     = sat16(w_sum_t[46:24]);
    assign w_v     = r_pix7.bri;

    // zero saturation needs no special path: all terms come out equal to V
    always_comb begin
        case (r_sec7)
            SEC_RED_YEL: begin
                n_red = w_v; n_green = w_t; n_blue = w_p;
            end
            SEC_YEL_GRN: begin
                n_red = w_q; n_green = w_v; n_blue = w_p;
            end
            SEC_GRN_CYN: begin
                n_red = w_p; n_green = w_v; n_blue = w_t;
            end
            SEC_CYN_BLU: begin
                n_red = w_p; n_green = w_q; n_blue = w_v;
            end
            SEC_BLU_MAG: begin
                n_red = w_t; n_green = w_p; n_blue = w_v;
            end
            default: begin
                n_red = w_v; n_green = w_p; n_blue = w_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix6.vld <= 1'b0;
            r_pix7.vld <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_pix6.vld <= i_pix.vld;
            r_pix7.vld <= r_pix6.vld;
            r_valid    <= r_pix7.vld;
        end
        r_pix6.sat <= i_pix.sat;
        r_pix6.bri <= i_pix.bri;
        r_pix6.alp <= i_pix.alp;
        r_pix7.sat <= r_pix6.sat;
        r_pix7.bri <= r_pix6.bri;
        r_pix7.alp <= r_pix6.alp;
        r_sec6     <= i_sec;
        r_sec7     <= r_sec6;
        r_in_p     <= n_in_p;
        r_in_q     <= n_in_q;
        r_in_t     <= n_in_t;
        r_pr_p     <= n_pr_p;
        r_pr_q     <= n_pr_q;
        r_pr_t     <= n_pr_t;
        r_red      <= n_red;
        r_green    <= n_green;
        r_blue     <= n_blue;
        r_alpha    <= r_pix7.alp;
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_alpha = r_alpha;

endmodule
